[hw/rtl/psi_extr_pkg.sv]
// Shared types and constants for the PSI section entry extractor.
`timescale 1ns / 1ps
`default_nettype none

package psi_extr_pkg;

    localparam int MAX_PAYLOAD = 4096;
    localparam int POS_W       = $clog2(MAX_PAYLOAD);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD - 1);

    localparam logic [7:0] TID_PAT = 8'h00;
    localparam logic [7:0] TID_PMT = 8'h02;
    localparam logic [7:0] TID_NIT = 8'h40;
    localparam logic [7:0] TID_SDT = 8'h42;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        TK_IDLE = 3'd0,
        TK_PAT  = 3'd1,
        TK_PMT  = 3'd2,
        TK_NIT  = 3'd3,
        TK_SDT  = 3'd4,
        TK_BAD  = 3'd5
    } t_table_kind;

    typedef enum logic [3:0] {
        EK_PAT_NET     = 4'd0,
        EK_PAT_PROG    = 4'd1,
        EK_PMT_PCR     = 4'd2,
        EK_PMT_STREAM  = 4'd3,
        EK_NIT_TS      = 4'd4,
        EK_SDT_HEADER  = 4'd5,
        EK_SDT_SERVICE = 4'd6,
        EK_OK          = 4'd7,
        EK_BAD_ID      = 4'd8,
        EK_TRUNCATED   = 4'd9
    } t_entry_kind;

    typedef struct packed {
        t_entry_kind  entry_kind;
        logic [15:0]  section_key;
        logic [15:0]  id_value;
        logic [15:0]  second_value;
        logic [7:0]   stream_type;
        logic         eit_schedule;
        logic         eit_present_following;
        logic [2:0]   running_status;
        logic         scrambled;
        logic [11:0]  descriptor_length;
        logic         last_of_section;
    } t_result;

    // Offset at which the entry loop starts once the header is done.
    function automatic logic [3:0] loop_start(input t_table_kind kind);
        logic [3:0] v;
        case (kind)
            TK_PMT:  v = 4'd4;
            TK_NIT:  v = 4'd4;
            TK_SDT:  v = 4'd3;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/psi_section_entry_extractor.sv]
// Top level of the PSI section entry extractor: byte parser and result queue.
//
// The slave channel takes one section payload byte per item, with the table id
// and table id extension in tdata, the first-byte mark in tuser and the
// last-byte mark in tlast. The table id on the first byte selects the PAT,
// PMT, NIT or SDT layout. The master channel gives one result per item: an
// entry when its last byte arrives, and a status result with tlast high on the
// last byte of the section. Descriptor loops are skipped by their length.
// Each accepted byte is parsed in the cycle it is accepted, and its results
// are written into a four-entry result queue that drives the master channel.
// One byte is taken every cycle while the queue holds two or fewer results; a
// last byte that also completes an entry puts two results into the queue at
// once. When the receiver stalls the queue fills and tready drops once three
// results are waiting. A synchronous active-low reset empties the queue and
// closes any open section; bytes that arrive with no section open are
// accepted and dropped without a result.
`timescale 1ns / 1ps
`default_nettype none

module psi_section_entry_extractor
    import psi_extr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // From bit 0: payload_byte[7:0], table_id[15:8], table_id_ext[31:16].
    input  wire logic [31:0] i_s_tdata,
    // Bit 0: first_byte.
    input  wire logic        i_s_tuser,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // From bit 0: section_key[15:0], id_value[31:16], second_value[47:32],
    // stream_type[55:48], eit_schedule[56], eit_present_following[57],
    // running_status[60:58], scrambled[61], descriptor_length[73:62], zeros.
    output logic [79:0]      o_m_tdata,
    // Bits 3:0: entry_kind.
    output logic [3:0]       o_m_tuser,
    output logic             o_m_tlast
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_off, n_off;
    logic [11:0]      r_skip, n_skip;
    t_table_kind      r_kind, n_kind;
    logic [47:0]      r_cap, n_cap;
    logic [1:0]       r_err, n_err;

    t_result          r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]  r_count;

    logic             s_acc, m_acc;
    logic [7:0]       in_byte, in_tid;
    logic [15:0]      in_key;
    logic             e_valid, st_valid;
    t_result          e_res, st_res;
    t_table_kind      kind_b;
    logic [POS_W-1:0] pos_b;
    logic [3:0]       off_b;
    logic [11:0]      skip_b;
    logic [47:0]      cap_b;
    logic [1:0]       err_b;
    logic [15:0]      w01;
    logic [11:0]      len4, len5, len6;

    assign in_byte = i_s_tdata[7:0];
    assign in_tid  = i_s_tdata[15:8];
    assign in_key  = i_s_tdata[31:16];

    assign o_s_tready = (r_count <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_count != '0);
    assign m_acc      = o_m_tvalid && i_m_tready;

    always_comb begin
        if (i_s_tuser) begin
            pos_b  = '0;
            off_b  = '0;
            skip_b = '0;
            cap_b  = '0;
            err_b  = '0;
            case (in_tid)
                TID_PAT: kind_b = TK_PAT;
                TID_PMT: kind_b = TK_PMT;
                TID_NIT: kind_b = TK_NIT;
                TID_SDT: kind_b = TK_SDT;
                default: kind_b = TK_BAD;
            endcase
        end else begin
            pos_b  = r_pos;
            off_b  = r_off;
            skip_b = r_skip;
            cap_b  = r_cap;
            err_b  = r_err;
            kind_b = r_kind;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_off    = r_off;
        n_skip   = r_skip;
        n_kind   = r_kind;
        n_cap    = r_cap;
        n_err    = r_err;
        e_valid  = 1'b0;
        st_valid = 1'b0;
        e_res    = '0;
        st_res   = '0;
        w01      = '0;
        len4     = '0;
        len5     = '0;
        len6     = '0;

        if (s_acc && (kind_b != TK_IDLE)) begin
            n_kind = kind_b;
            n_off  = off_b;
            n_skip = skip_b;
            n_cap  = cap_b;
            n_err  = err_b;
            n_pos  = pos_b;
            if (err_b[1]) begin
                n_err[0] = 1'b1;
            end else if (pos_b >= POS_LIMIT) begin
                n_err[1] = 1'b1;
            end else begin
                n_pos = pos_b + POS_W'(1);
            end

            if (kind_b != TK_BAD) begin
                n_cap = {cap_b[39:0], in_byte};
                w01   = n_cap[15:0];
                len4  = {n_cap[11:8], n_cap[7:0]};
                len5  = {n_cap[11:8], n_cap[7:0]};
                len6  = {n_cap[11:8], n_cap[7:0]};
                e_res.section_key = in_key;
                if (skip_b != '0) begin
                    n_skip = skip_b - 12'd1;
                end else begin
                    n_off = off_b + 4'd1;
                    case (kind_b)
                        TK_PAT: begin
                            if (off_b >= 4'd3) begin
                                e_valid = 1'b1;
                                e_res.id_value = n_cap[31:16];
                                e_res.entry_kind = (n_cap[31:16] == 16'd0) ?
                                    EK_PAT_NET : EK_PAT_PROG;
                                e_res.second_value = {3'b000, n_cap[12:8], n_cap[7:0]};
                                n_off = 4'd0;
                            end
                        end
                        TK_PMT: begin
                            if (off_b == 4'd3) begin
                                e_valid = 1'b1;
                                e_res.entry_kind = EK_PMT_PCR;
                                e_res.id_value = in_key;
                                e_res.second_value = {3'b000, n_cap[28:24], n_cap[23:16]};
                                e_res.descriptor_length = len4;
                                n_skip = len4;
                                n_off  = 4'd4;
                            end else if (off_b >= 4'd8) begin
                                e_valid = 1'b1;
                                e_res.entry_kind = EK_PMT_STREAM;
                                e_res.id_value = in_key;
                                e_res.second_value = {3'b000, n_cap[28:24], n_cap[23:16]};
                                e_res.stream_type = n_cap[39:32];
                                e_res.descriptor_length = len5;
                                n_skip = len5;
                                n_off  = 4'd4;
                            end
                        end
                        TK_NIT: begin
                            if (off_b == 4'd1) begin
                                n_skip = {w01[11:8], w01[7:0]};
                                n_off  = 4'd2;
                            end else if (off_b >= 4'd9) begin
                                e_valid = 1'b1;
                                e_res.entry_kind = EK_NIT_TS;
                                e_res.id_value = n_cap[47:32];
                                e_res.second_value = n_cap[31:16];
                                e_res.descriptor_length = len6;
                                n_skip = len6;
                                n_off  = 4'd4;
                            end
                        end
                        TK_SDT: begin
                            if (off_b == 4'd1) begin
                                e_valid = 1'b1;
                                e_res.entry_kind = EK_SDT_HEADER;
                                e_res.id_value = in_key;
                                e_res.second_value = w01;
                                n_off = 4'd2;
                            end else if (off_b >= 4'd7) begin
                                e_valid = 1'b1;
                                e_res.entry_kind = EK_SDT_SERVICE;
                                e_res.id_value = n_cap[39:24];
                                e_res.eit_schedule = n_cap[17];
                                e_res.eit_present_following = n_cap[16];
                                e_res.running_status = n_cap[15:13];
                                e_res.scrambled = n_cap[12];
                                e_res.descriptor_length = len5;
                                n_skip = len5;
                                n_off  = 4'd3;
                            end
                        end
                        default: begin
                            n_off = off_b;
                        end
                    endcase
                end
            end

            if (i_s_tlast) begin
                st_valid = 1'b1;
                st_res.section_key = in_key;
                st_res.last_of_section = 1'b1;
                if (kind_b == TK_BAD) begin
                    st_res.entry_kind = EK_BAD_ID;
                end else if (n_err[0]) begin
                    st_res.entry_kind = EK_TRUNCATED;
                end else if ((n_skip != '0) || (n_off != loop_start(kind_b))) begin
                    st_res.entry_kind = EK_TRUNCATED;
                end else begin
                    st_res.entry_kind = EK_OK;
                end
                n_kind = TK_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_off  <= '0;
            r_skip <= '0;
            r_kind <= TK_IDLE;
            r_cap  <= '0;
            r_err  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_off  <= n_off;
            r_skip <= n_skip;
            r_kind <= n_kind;
            r_cap  <= n_cap;
            r_err  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_valid) begin
            r_q[r_wr] <= e_res;
        end
        if (st_valid) begin
            r_q[r_wr + QPTR_W'(e_valid)] <= st_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(e_valid) + QPTR_W'(st_valid);
            r_rd    <= r_rd + QPTR_W'(m_acc);
            r_count <= r_count + (QPTR_W+1)'(e_valid) + (QPTR_W+1)'(st_valid)
                       - (QPTR_W+1)'(m_acc);
        end
    end

    t_result out_res;
    assign out_res   = r_q[r_rd];
    assign o_m_tuser = out_res.entry_kind;
    assign o_m_tlast = out_res.last_of_section;
    assign o_m_tdata = {6'd0,
                        out_res.descriptor_length,
                        out_res.scrambled,
                        out_res.running_status,
                        out_res.eit_present_following,
                        out_res.eit_schedule,
                        out_res.stream_type,
                        out_res.second_value,
                        out_res.id_value,
                        out_res.section_key};

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("Result queue holds more items than its depth.");

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_count >= (QPTR_W+1)'(QUEUE_DEPTH - 1)))
        else $error("Input stalled while the result queue has room for two items.");

    a_close_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (r_kind == TK_IDLE))
        else $error("Section still open after its last byte.");

    a_status_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast && (kind_b != TK_IDLE)) |=> (r_count != '0))
        else $error("Last byte of a section left no status item in the queue.");

    a_err_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err[0] |-> r_err[1])
        else $error("Overlength flagged before the payload limit was reached.");

endmodule

`default_nettype wire
